### rtl/spectral_false_color_map_assert.svh
// Assertion macros shared by the RTL of the false-colour map.
// Each expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef SPECTRAL_FALSE_COLOR_MAP_ASSERT_SVH
`define SPECTRAL_FALSE_COLOR_MAP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define SFCM_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define SFCM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/sfcm_pkg.sv
package sfcm_pkg;

	// Palette geometry
	localparam int unsigned PalSize   = 208;
	localparam int unsigned RampSteps = 52;
	localparam int unsigned YellowIdx = 51;

	// Fixed-point widths
	localparam int unsigned SampleW = 18;	// Q2.16 input
	localparam int unsigned FracW   = 17;	// clamped 0..65536
	localparam int unsigned NumW    = 24;	// divider dividend / remainder
	localparam int unsigned QuoW    = 8;	// divider quotient
	localparam int unsigned BandW   = 16;	// shifted band divisor

	// Configuration register indexes
	localparam logic [1:0] REG_BOUNDARY = 2'd0;
	localparam logic [1:0] REG_GRAY     = 2'd1;
	localparam logic [1:0] REG_GAP      = 2'd2;
	localparam logic [1:0] REG_BAND     = 2'd3;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

	typedef struct packed {
		logic             qbit;
		logic [NumW-1:0]  rem;
	} div_step_t;

	// Divisor aligned to quotient bit k
	function automatic logic [NumW-1:0] div_shift(input logic [FracW-1:0] d, input int unsigned k);
		logic [NumW-1:0] ext;
		ext = {{(NumW-FracW){1'b0}}, d};
		return ext << k;
	endfunction

	// One restoring division step
	function automatic div_step_t div_step(input logic [NumW-1:0] rem,
			input logic [NumW-1:0] dsh);
		div_step_t res;
		if (rem >= dsh) begin
			res.qbit = 1'b1;
			res.rem  = rem - dsh;
		end else begin
			res.qbit = 1'b0;
			res.rem  = rem;
		end
		return res;
	endfunction

	// One remainder step of the band floor; only the remainder is kept
	function automatic logic [7:0] band_step(input logic [7:0] rem, input logic [7:0] band,
			input int unsigned k);
		logic [BandW-1:0] dsh;
		logic [BandW-1:0] wide;
		dsh  = {8'd0, band} << k;
		wide = {8'd0, rem};
		if (wide >= dsh)
			return 8'(wide - dsh);
		else
			return rem;
	endfunction

	// Four ramps: green up, red down, blue up, green down
	function automatic rgb_t palette_rgb(input logic [7:0] slot);
		rgb_t       c;
		logic [7:0] st;
		logic [7:0] lvl;
		priority if (slot < 8'(RampSteps)) begin
			st = slot;
		end else if (slot < 8'(2 * RampSteps)) begin
			st = slot - 8'(RampSteps);
		end else if (slot < 8'(3 * RampSteps)) begin
			st = slot - 8'(2 * RampSteps);
		end else begin
			st = slot - 8'(3 * RampSteps);
		end
		lvl = {st[5:0], 2'b00} + st;
		priority if (slot < 8'(RampSteps)) begin
			c = '{red: 8'd255, green: lvl, blue: 8'd0};
		end else if (slot < 8'(2 * RampSteps)) begin
			c = '{red: 8'd255 - lvl, green: 8'd255, blue: 8'd0};
		end else if (slot < 8'(3 * RampSteps)) begin
			c = '{red: 8'd0, green: 8'd255, blue: lvl};
		end else begin
			c = '{red: 8'd0, green: 8'd255 - lvl, blue: 8'd255};
		end
		return c;
	endfunction

endpackage

### rtl/spectral_false_color_map.sv
// Channel   Handshake                   Payload
// sample    sample_valid/sample_stall   sample_value
// color     color_valid/color_stall     red, green, blue, palette_slot
// config    wr_en (no wait)             wr_index, wr_data
//
// Twelve register stages; one beat accepted per cycle while the output is not stalled.
// Depth is set by the eight-bit restoring divider (two quotient bits per stage)
// followed by the band floor (four remainder steps per stage).
// arst_n clears the valid bits and configuration; no clearing pass is needed.
// A stalled output beat freezes the whole pipeline; sample_stall follows it.
`include "spectral_false_color_map_assert.svh"

module spectral_false_color_map
	import sfcm_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               sample_valid,
	output logic               sample_stall,
	input  logic [SampleW-1:0] sample_value,
	output logic               color_valid,
	input  logic               color_stall,
	output logic [7:0]         red,
	output logic [7:0]         green,
	output logic [7:0]         blue,
	output logic [7:0]         palette_slot,
	input  logic               wr_en,
	input  logic [1:0]         wr_index,
	input  logic [15:0]        wr_data
);

	// Configuration registers
	logic [15:0] boundary_q;
	logic        gray_q;
	logic [5:0]  gap_q;
	logic [7:0]  band_q;
	logic [7:0]  band_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			boundary_q <= '0;
			gray_q     <= 1'b0;
			gap_q      <= '0;
			band_q     <= 8'd1;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_BOUNDARY: boundary_q <= wr_data;
				REG_GRAY:     gray_q     <= wr_data[0];
				REG_GAP:      gap_q      <= wr_data[5:0];
				REG_BAND:     band_q     <= wr_data[7:0];
			endcase
		end
	end

	// Zero band behaves as one
	assign band_eff = (band_q == 8'd0) ? 8'd1 : band_q;

	// Pipeline advance: everything moves unless the output beat is held
	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10, v_s11, v_s12;

	assign en           = !v_s12 || !color_stall;
	assign sample_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6}    <= '0;
			{v_s7, v_s8, v_s9, v_s10, v_s11, v_s12} <= '0;
		end else if (en) begin
			v_s1  <= sample_valid;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
			v_s12 <= v_s11;
		end
	end

	// Stage 1: clamp to 0..1.0
	logic [FracW-1:0] frac_d;
	logic [FracW-1:0] frac_s1;

	always_comb begin
		if (sample_value[SampleW-1])
			frac_d = '0;
		else if (sample_value[FracW-1:0] > 17'h10000)
			frac_d = 17'h10000;
		else
			frac_d = sample_value[FracW-1:0];
	end

	// Stage 2: range select, dividend and divisor
	logic [NumW-1:0]  v100, b95, b105;
	logic [NumW:0]    p207;
	logic [5:0]       lo_span;
	logic [7:0]       hi_span;
	logic [FracW-1:0] hi_diff;
	logic [NumW:0]    hi_prod;
	logic [NumW-1:0]  num_d;
	logic [FracW-1:0] den_d;
	logic [7:0]       base_d;
	logic             use_div_d;

	always_comb begin
		v100    = NumW'(frac_s1) * NumW'(100);
		b95     = NumW'(boundary_q) * NumW'(95);
		b105    = NumW'(boundary_q) * NumW'(105);
		p207    = (NumW+1)'(frac_s1) * (NumW+1)'(207);
		lo_span = 6'(YellowIdx) - gap_q;
		hi_span = 8'(PalSize - 1 - YellowIdx) - {2'b00, gap_q};
		hi_diff = frac_s1 - {1'b0, boundary_q};
		hi_prod = (NumW+1)'(hi_diff) * (NumW+1)'(hi_span);
		num_d     = '0;
		den_d     = {1'b0, boundary_q};
		base_d    = 8'(YellowIdx);
		use_div_d = 1'b0;
		priority if (boundary_q == 16'd0) begin
			base_d = p207[23:16];
		end else if (v100 <= b95) begin
			base_d = 8'd0;
			// a gap wider than yellow drives the lower index to zero
			if (gap_q <= 6'(YellowIdx)) begin
				num_d     = NumW'(frac_s1) * NumW'(lo_span);
				use_div_d = 1'b1;
			end
		end else if (v100 >= b105) begin
			base_d    = 8'(YellowIdx) + {2'b00, gap_q};
			num_d     = hi_prod[NumW-1:0];
			den_d     = 17'h10000 - {1'b0, boundary_q};
			use_div_d = 1'b1;
		end else begin
			base_d = 8'(YellowIdx);	// dead zone around yellow
		end
	end

	logic [NumW-1:0]  rem_s2, rem_s3, rem_s4, rem_s5;
	logic [FracW-1:0] den_s2, den_s3, den_s4, den_s5;
	logic [7:0]       base_s2, base_s3, base_s4, base_s5, base_s6;
	logic             use_div_s2, use_div_s3, use_div_s4, use_div_s5, use_div_s6;
	logic [1:0]       q_s3;
	logic [3:0]       q_s4;
	logic [5:0]       q_s5;
	logic [QuoW-1:0]  q_s6;

	// Stages 3-6: restoring divider, two quotient bits per stage
	div_step_t d7, d6, d5, d4, d3, d2, d1, d0;

	always_comb begin
		d7 = div_step(rem_s2,  div_shift(den_s2, 7));
		d6 = div_step(d7.rem,  div_shift(den_s2, 6));
		d5 = div_step(rem_s3,  div_shift(den_s3, 5));
		d4 = div_step(d5.rem,  div_shift(den_s3, 4));
		d3 = div_step(rem_s4,  div_shift(den_s4, 3));
		d2 = div_step(d3.rem,  div_shift(den_s4, 2));
		d1 = div_step(rem_s5,  div_shift(den_s5, 1));
		d0 = div_step(d1.rem,  div_shift(den_s5, 0));
	end

	// Stage 7: final index; bounded to 207 by construction of each range
	logic [7:0] idx_s7, idx_s8, idx_s9;
	logic [7:0] brem_s8, brem_s9;
	logic [7:0] br7, br6, br5, br4, br3, br2, br1, br0;

	// Stages 8-9: band floor via remainder, four steps per stage
	always_comb begin
		br7 = band_step(idx_s7, band_eff, 7);
		br6 = band_step(br7,    band_eff, 6);
		br5 = band_step(br6,    band_eff, 5);
		br4 = band_step(br5,    band_eff, 4);
		br3 = band_step(brem_s8, band_eff, 3);
		br2 = band_step(br3,     band_eff, 2);
		br1 = band_step(br2,     band_eff, 1);
		br0 = band_step(br1,     band_eff, 0);
	end

	// Stages 10-12: slot, palette and grey level
	logic [7:0]  slot_s10, slot_s11;
	logic [7:0]  gray_n;
	logic [15:0] gray_x;
	logic [11:0] gray_y_s11;
	logic [24:0] gray_prod;
	rgb_t        pal_s11;
	rgb_t        rgb_s12;
	logic [7:0]  slot_s12;

	always_comb begin
		gray_n    = 8'(PalSize) - slot_s10;
		gray_x    = {gray_n, 8'd0} - {8'd0, gray_n};	// times 255
		gray_prod = {13'd0, gray_y_s11} * 25'd5042;	// divide by 13, exact below 6553
	end

	always_ff @(posedge clk) begin
		if (en) begin
			frac_s1    <= frac_d;

			rem_s2     <= num_d;
			den_s2     <= den_d;
			base_s2    <= base_d;
			use_div_s2 <= use_div_d;

			rem_s3     <= d6.rem;
			q_s3       <= {d7.qbit, d6.qbit};
			den_s3     <= den_s2;
			base_s3    <= base_s2;
			use_div_s3 <= use_div_s2;

			rem_s4     <= d4.rem;
			q_s4       <= {q_s3, d5.qbit, d4.qbit};
			den_s4     <= den_s3;
			base_s4    <= base_s3;
			use_div_s4 <= use_div_s3;

			rem_s5     <= d2.rem;
			q_s5       <= {q_s4, d3.qbit, d2.qbit};
			den_s5     <= den_s4;
			base_s5    <= base_s4;
			use_div_s5 <= use_div_s4;

			q_s6       <= {q_s5, d1.qbit, d0.qbit};
			base_s6    <= base_s5;
			use_div_s6 <= use_div_s5;

			idx_s7     <= base_s6 + (use_div_s6 ? q_s6 : 8'd0);

			idx_s8     <= idx_s7;
			brem_s8    <= br4;

			idx_s9     <= idx_s8;
			brem_s9    <= br0;

			slot_s10   <= idx_s9 - brem_s9;

			slot_s11   <= slot_s10;
			pal_s11    <= palette_rgb(slot_s10);
			gray_y_s11 <= gray_x[15:4];

			slot_s12   <= slot_s11;
			if (gray_q)
				rgb_s12 <= '{red: gray_prod[23:16], green: gray_prod[23:16],
					blue: gray_prod[23:16]};
			else
				rgb_s12 <= pal_s11;
		end
	end

	assign color_valid  = v_s12;
	assign red          = rgb_s12.red;
	assign green        = rgb_s12.green;
	assign blue         = rgb_s12.blue;
	assign palette_slot = slot_s12;

	// Checks
	`SFCM_ASSERT_NEXT(a_accept_fills_s1, sample_valid && !sample_stall, v_s1, "accepted beat lost at stage 1")
	`SFCM_ASSERT_NOW(a_slot_in_range, color_valid, palette_slot <= 8'(PalSize - 1), "palette slot beyond palette")
	`SFCM_ASSERT_NOW(a_gray_equal, color_valid && gray_q, (red == green) && (green == blue), "grey channels differ")
	`SFCM_ASSERT_NOW(a_palette_saturated, color_valid && !gray_q, (red == 8'd255) || (green == 8'd255) || (blue == 8'd255), "palette colour has no full channel")

endmodule

### tb/tb.sv
module tb;
	import sfcm_pkg::*;

	// Palette geometry and fixed-point scale, kept signed for the index arithmetic
	localparam longint NumSlots   = 208;
	localparam longint TopSlot    = 207;
	localparam longint RampLen    = 52;
	localparam longint YellowSlot = 51;
	localparam longint UnitQ16    = 65536;
	localparam longint StepLevel  = 5;
	localparam int     MaxWait    = 17;
	localparam int     PhaseCount = 9;
	localparam int     PhaseBeats = 150;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] slot;
	} color_beat_t;

	typedef struct packed {
		logic [15:0]        boundary;
		logic               gray;
		logic [5:0]         gap;
		logic [7:0]         band;
		logic [SampleW-1:0] sample;
		logic               known;
		color_beat_t        want;
	} directed_row_t;

	// Settings and sample, then the colour where it is obvious by inspection
	localparam directed_row_t DirectedRows [25] = '{
		'{16'h0000, 1'b0, 6'd0,  8'd1,   18'h00000, 1'b1, '{8'd255, 8'd0,   8'd0,   8'd0}},
		'{16'h0000, 1'b0, 6'd0,  8'd1,   18'h10000, 1'b1, '{8'd0,   8'd0,   8'd255, 8'd207}},
		'{16'h0000, 1'b0, 6'd0,  8'd1,   18'h1FFFF, 1'b1, '{8'd0,   8'd0,   8'd255, 8'd207}},
		'{16'h0000, 1'b0, 6'd0,  8'd1,   18'h20000, 1'b1, '{8'd255, 8'd0,   8'd0,   8'd0}},
		'{16'h0000, 1'b0, 6'd0,  8'd1,   18'h3FFFF, 1'b1, '{8'd255, 8'd0,   8'd0,   8'd0}},
		'{16'h0000, 1'b0, 6'd0,  8'd1,   18'h08000, 1'b1, '{8'd0,   8'd255, 8'd0,   8'd103}},
		'{16'h0000, 1'b0, 6'd0,  8'd1,   18'h04000, 1'b1, '{8'd255, 8'd255, 8'd0,   8'd51}},
		'{16'h0000, 1'b1, 6'd0,  8'd1,   18'h00000, 1'b1, '{8'd255, 8'd255, 8'd255, 8'd0}},
		'{16'h0000, 1'b1, 6'd0,  8'd1,   18'h10000, 1'b1, '{8'd1,   8'd1,   8'd1,   8'd207}},
		'{16'h0000, 1'b1, 6'd0,  8'd1,   18'h08000, 1'b1, '{8'd128, 8'd128, 8'd128, 8'd103}},
		'{16'h0000, 1'b0, 6'd0,  8'd52,  18'h10000, 1'b1, '{8'd0,   8'd255, 8'd255, 8'd156}},
		'{16'h0000, 1'b0, 6'd0,  8'd208, 18'h10000, 1'b1, '{8'd255, 8'd0,   8'd0,   8'd0}},
		'{16'h0000, 1'b0, 6'd0,  8'd0,   18'h10000, 1'b1, '{8'd0,   8'd0,   8'd255, 8'd207}},
		'{16'h0000, 1'b0, 6'd0,  8'd255, 18'h10000, 1'b1, '{8'd255, 8'd0,   8'd0,   8'd0}},
		'{16'h8000, 1'b0, 6'd0,  8'd1,   18'h00000, 1'b1, '{8'd255, 8'd0,   8'd0,   8'd0}},
		'{16'h8000, 1'b0, 6'd0,  8'd1,   18'd31129, 1'b0, '0},
		'{16'h8000, 1'b0, 6'd0,  8'd1,   18'h08000, 1'b1, '{8'd255, 8'd255, 8'd0,   8'd51}},
		'{16'h8000, 1'b0, 6'd0,  8'd1,   18'd34407, 1'b0, '0},
		'{16'h8000, 1'b0, 6'd0,  8'd1,   18'h10000, 1'b1, '{8'd0,   8'd0,   8'd255, 8'd207}},
		'{16'h8000, 1'b0, 6'd63, 8'd1,   18'h04000, 1'b1, '{8'd255, 8'd0,   8'd0,   8'd0}},
		'{16'h8000, 1'b0, 6'd63, 8'd1,   18'd40000, 1'b0, '0},
		'{16'hFFFF, 1'b0, 6'd0,  8'd1,   18'h10000, 1'b1, '{8'd255, 8'd255, 8'd0,   8'd51}},
		'{16'hFFFF, 1'b0, 6'd0,  8'd1,   18'd62258, 1'b0, '0},
		'{16'h0001, 1'b0, 6'd0,  8'd1,   18'h00001, 1'b1, '{8'd255, 8'd255, 8'd0,   8'd51}},
		'{16'h0001, 1'b0, 6'd51, 8'd1,   18'h10000, 1'b0, '0}
	};

	logic               clk          = 1'b0;
	logic               arst_n       = 1'b0;
	logic               sample_valid = 1'b0;
	logic               sample_stall;
	logic [SampleW-1:0] sample_value = '0;
	logic               color_valid;
	logic               color_stall  = 1'b0;
	logic [7:0]         red;
	logic [7:0]         green;
	logic [7:0]         blue;
	logic [7:0]         palette_slot;
	logic               wr_en        = 1'b0;
	logic [1:0]         wr_index     = REG_BOUNDARY;
	logic [15:0]        wr_data      = '0;

	// Shadow of the block's configuration
	logic [15:0] cfg_boundary = 16'd0;
	logic        cfg_gray     = 1'b0;
	logic [5:0]  cfg_gap      = 6'd0;
	logic [7:0]  cfg_band     = 8'd1;

	color_beat_t pending_colors [$];
	int          fail_count = 0;
	bit          src_calm   = 1'b0;
	bit          sink_calm  = 1'b0;

	spectral_false_color_map uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample_value (sample_value),
		.color_valid  (color_valid),
		.color_stall  (color_stall),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.palette_slot (palette_slot),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("Test completed with failures");
		$finish;
	end

	function automatic int unsigned draw_wait(input bit calm);
		return calm ? 0 : $urandom_range(0, MaxWait);
	endfunction

	// Colour expected for one sample under the current shadow settings
	function automatic color_beat_t map_sample(input logic [SampleW-1:0] raw);
		color_beat_t c;
		longint      v;
		longint      b;
		longint      g;
		longint      idx;
		longint      band;
		longint      slot;
		longint      lvl;
		longint      step;
		v = longint'($signed(raw));
		if (v < 0)
			v = 0;
		else if (v > UnitQ16)
			v = UnitQ16;
		b = longint'(cfg_boundary);
		g = longint'(cfg_gap);
		// Index: plain scale, lower range, upper range or dead zone at yellow
		if (b == 0)
			idx = v * TopSlot / UnitQ16;
		else if (100 * v <= 95 * b)
			idx = (g >= YellowSlot) ? 0 : v * (YellowSlot - g) / b;
		else if (100 * v >= 105 * b)
			idx = YellowSlot + g + (v - b) * (TopSlot - YellowSlot - g) / (UnitQ16 - b);
		else
			idx = YellowSlot;
		if (idx < 0)
			idx = 0;
		else if (idx > TopSlot)
			idx = TopSlot;
		// Banding; a zero band behaves as one
		band = (cfg_band == 8'd0) ? 1 : longint'(cfg_band);
		slot = (idx / band) * band;
		c.slot = 8'(slot);
		if (cfg_gray) begin
			lvl = (NumSlots - slot) * 255 / NumSlots;
			c.red   = 8'(lvl);
			c.green = 8'(lvl);
			c.blue  = 8'(lvl);
		end else begin
			step = StepLevel * (slot % RampLen);
			case (slot / RampLen)
				0: begin
					c.red = 8'd255; c.green = 8'(step); c.blue = 8'd0;
				end
				1: begin
					c.red = 8'(255 - step); c.green = 8'd255; c.blue = 8'd0;
				end
				2: begin
					c.red = 8'd0; c.green = 8'd255; c.blue = 8'(step);
				end
				default: begin
					c.red = 8'd0; c.green = 8'(255 - step); c.blue = 8'd255;
				end
			endcase
		end
		return c;
	endfunction

	// Offer one sample beat, hold it until taken, then log what should come out
	task automatic push_sample(input logic [SampleW-1:0] raw, input logic known,
			input color_beat_t want);
		int unsigned idle;
		idle = draw_wait(src_calm);
		@(negedge clk);
		if (idle > 0) begin
			sample_valid <= 1'b0;
			repeat (idle) @(negedge clk);
		end
		sample_valid <= 1'b1;
		sample_value <= raw;
		do @(posedge clk); while (sample_stall);
		pending_colors.push_back(known ? want : map_sample(raw));
	endtask

	// Stop offering and let the pipe empty out
	task automatic drain();
		@(negedge clk);
		sample_valid <= 1'b0;
		while (pending_colors.size() != 0) @(posedge clk);
	endtask

	// Upper bits of the write data are junk and must be ignored
	task automatic write_reg(input logic [1:0] idx, input logic [15:0] value,
			input logic [15:0] keep);
		logic [15:0] data;
		data = (16'($urandom) & ~keep) | (value & keep);
		@(negedge clk);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= data;
		case (idx)
			REG_BOUNDARY: cfg_boundary = data;
			REG_GRAY:     cfg_gray     = data[0];
			REG_GAP:      cfg_gap      = data[5:0];
			REG_BAND:     cfg_band     = data[7:0];
			default:      ;
		endcase
		@(negedge clk);
		wr_en <= 1'b0;
	endtask

	task automatic apply_settings(input logic [15:0] boundary, input logic gray,
			input logic [5:0] gap, input logic [7:0] band);
		drain();
		write_reg(REG_BOUNDARY, boundary, 16'hFFFF);
		write_reg(REG_GRAY, {15'd0, gray}, 16'h0001);
		write_reg(REG_GAP, {10'd0, gap}, 16'h003F);
		write_reg(REG_BAND, {8'd0, band}, 16'h00FF);
	endtask

	task automatic check_field(input string what, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
			fail_count++;
		end
	endtask

	// Colour beats: compare against the oldest expectation
	always @(posedge clk) begin : color_check
		color_beat_t want;
		if (arst_n && color_valid && !color_stall) begin
			if (pending_colors.size() == 0) begin
				$display("%0t: unexpected colour beat, expected none, got %0d %0d %0d slot %0d",
					$time, red, green, blue, palette_slot);
				fail_count++;
			end else begin
				want = pending_colors.pop_front();
				check_field("red", want.red, red);
				check_field("green", want.green, green);
				check_field("blue", want.blue, blue);
				check_field("palette_slot", want.slot, palette_slot);
			end
		end
	end

	// Colour side back-pressure
	initial begin : color_sink
		int unsigned hold;
		@(posedge arst_n);
		forever begin
			hold = draw_wait(sink_calm);
			@(negedge clk);
			if (hold > 0) begin
				color_stall <= 1'b1;
				repeat (hold) @(negedge clk);
			end
			color_stall <= 1'b0;
			do @(posedge clk); while (!color_valid);
		end
	end

	initial begin : stimulus
		directed_row_t       row;
		logic [15:0]         boundary;
		logic [5:0]          gap;
		logic [7:0]          band;
		logic [SampleW-1:0]  raw;
		int                  centre;
		int                  spot;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed rows; settings change only between drained beats
		src_calm  = $urandom_range(0, 1);
		sink_calm = $urandom_range(0, 1);
		foreach (DirectedRows[i]) begin
			row = DirectedRows[i];
			if ({row.boundary, row.gray, row.gap, row.band} !=
					{cfg_boundary, cfg_gray, cfg_gap, cfg_band})
				apply_settings(row.boundary, row.gray, row.gap, row.band);
			push_sample(row.sample, row.known, row.want);
		end

		// Random phases, each under fresh settings
		for (int phase = 0; phase < PhaseCount; phase++) begin
			case ($urandom_range(0, 5))
				0:       boundary = 16'd0;
				1:       boundary = $urandom_range(0, 1) ? 16'd1 : 16'hFFFF;
				default: boundary = 16'($urandom_range(1, 65535));
			endcase
			case ($urandom_range(0, 3))
				0:       gap = 6'd0;
				1:       gap = $urandom_range(0, 1) ? 6'd51 : 6'd63;
				default: gap = 6'($urandom_range(0, 63));
			endcase
			case ($urandom_range(0, 4))
				0: band = 8'd1;
				1: begin
					case ($urandom_range(0, 3))
						0:       band = 8'd0;
						1:       band = 8'd208;
						2:       band = 8'd255;
						default: band = 8'd52;
					endcase
				end
				2:       band = 8'($urandom_range(1, 16));
				default: band = 8'($urandom_range(1, 208));
			endcase
			apply_settings(boundary, 1'($urandom), gap, band);
			src_calm  = (phase == 0) || ($urandom_range(0, 3) == 0);
			sink_calm = (phase == 0) || ($urandom_range(0, 3) == 0);

			for (int n = 0; n < PhaseBeats; n++) begin
				case ($urandom_range(0, 9))
					// Any pattern, negative and over-range included
					0: raw = SampleW'($urandom);
					1: begin
						case ($urandom_range(0, 5))
							0:       raw = 18'h00000;
							1:       raw = 18'h10000;
							2:       raw = 18'h1FFFF;
							3:       raw = 18'h20000;
							4:       raw = 18'h3FFFF;
							default: raw = 18'h0FFFF;
						endcase
					end
					// Around the dead-zone edges and the split point
					2, 3: begin
						spot = $urandom_range(0, 2);
						centre = (spot == 0) ? int'(cfg_boundary) * 95 / 100 :
							(spot == 1) ? int'(cfg_boundary) : int'(cfg_boundary) * 105 / 100;
						raw = SampleW'(centre + int'($urandom_range(0, 128)) - 64);
					end
					default: raw = SampleW'($urandom_range(0, 65536));
				endcase
				push_sample(raw, 1'b0, '0);
			end
		end

		drain();
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
